// ----- design/sphc_pkg.sv -----
`default_nettype none
package sphc_pkg;

    localparam int unsigned POS_W       = 32;
    localparam int unsigned THRESH_W    = 10;
    localparam int unsigned HOLDOFF_W   = 16;
    localparam int unsigned LOAD_W      = 10;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 80;
    localparam int unsigned OUT_DATA_W  = 104;

    localparam logic [POS_W-1:0]     POS_MAX       = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]     POS_ZERO      = 32'h0000_0000;
    localparam logic [POS_W-1:0]     MAX_POS_RESET = 32'd60000;
    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 10'd40;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd500;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_TARGET = 2'd1,
        REQ_HOME   = 2'd2,
        REQ_STALL  = 2'd3
    } t_req;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REVERSE   = 3'd0,
        CFG_HOME_ZERO = 3'd1,
        CFG_HOME_MAX  = 3'd2,
        CFG_THRESHOLD = 3'd3,
        CFG_HOLDOFF   = 3'd4
    } t_cfg_idx;

endpackage
`default_nettype wire

// ----- design/stepper_position_homing_controller.sv -----
// data path: input register, single update stage, result register
// throughput: one transaction per cycle while m_axis_tready does not stall it
// a stalled result register holds a full input register, which holds tready low
// reset (synchronous, active low): position and target zero, maximum 60000,
// homing off, pins low, stall threshold 40, holdoff 500 ms
`default_nettype none
module stepper_position_homing_controller (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // config write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [sphc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [sphc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // request stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // target_position, driver_enabled, load_value, now_ms, zero pad
    input  wire logic [sphc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // req_type
    input  wire logic [sphc_pkg::REQ_W-1:0]           s_axis_tuser,
    // result stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // step_level, dir_level, position_now, target_now, max_position_now,
    // moving, homing_active, save_request, zero pad
    output logic [sphc_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

    localparam int unsigned PW = sphc_pkg::POS_W;

    // configuration
    logic                              r_reverse;
    logic                              r_home_zero;
    logic                              r_home_max;
    logic [sphc_pkg::THRESH_W-1:0]     r_threshold;
    logic [sphc_pkg::HOLDOFF_W-1:0]    r_holdoff;

    // input register
    logic                              r_in_valid;
    sphc_pkg::t_req                    r_req;
    logic [PW-1:0]                     r_tgt;
    logic                              r_drv;
    logic [sphc_pkg::LOAD_W-1:0]       r_load;
    logic [sphc_pkg::TIME_W-1:0]       r_now;

    // controller state
    logic [PW-1:0]                     r_pos, n_pos;
    logic [PW-1:0]                     r_set, n_set;
    logic [PW-1:0]                     r_maxp, n_maxp;
    logic                              r_step, n_step;
    logic                              r_dir, n_dir;
    logic                              r_homing, n_homing;
    logic                              r_tmax, n_tmax;
    logic                              r_moving, n_moving;
    logic [sphc_pkg::TIME_W-1:0]       r_last, n_last;
    logic                              n_save;

    // result register
    logic                              r_out_valid;
    logic [sphc_pkg::OUT_DATA_W-1:0]   r_out_data;

    logic                              advance;
    logic                              work;
    logic                              step_go;
    logic                              up;
    logic [sphc_pkg::TIME_W-1:0]       elapsed;
    logic [sphc_pkg::TIME_W-1:0]       holdoff_ext;

    assign advance       = !r_out_valid || m_axis_tready;
    assign work          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse   <= 1'b0;
            r_home_zero <= 1'b0;
            r_home_max  <= 1'b0;
            r_threshold <= sphc_pkg::THRESH_RESET;
            r_holdoff   <= sphc_pkg::HOLDOFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sphc_pkg::CFG_REVERSE:   r_reverse   <= i_cfg_wdata[0];
                sphc_pkg::CFG_HOME_ZERO: r_home_zero <= i_cfg_wdata[0];
                sphc_pkg::CFG_HOME_MAX:  r_home_max  <= i_cfg_wdata[0];
                sphc_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_wdata[sphc_pkg::THRESH_W-1:0];
                sphc_pkg::CFG_HOLDOFF:   r_holdoff   <= i_cfg_wdata[sphc_pkg::HOLDOFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req  <= sphc_pkg::t_req'(s_axis_tuser);
            r_tgt  <= s_axis_tdata[31:0];
            r_drv  <= s_axis_tdata[32];
            r_load <= s_axis_tdata[42:33];
            r_now  <= s_axis_tdata[74:43];
        end
    end

    assign elapsed     = r_now - r_last;
    assign holdoff_ext = {{(sphc_pkg::TIME_W-sphc_pkg::HOLDOFF_W){1'b0}}, r_holdoff};
    assign step_go     = ((r_pos != r_set) || r_homing) && r_drv;
    assign up          = r_homing ? r_tmax : (r_pos < r_set);

    always_comb begin
        n_pos    = r_pos;
        n_set    = r_set;
        n_maxp   = r_maxp;
        n_step   = r_step;
        n_dir    = r_dir;
        n_homing = r_homing;
        n_tmax   = r_tmax;
        n_moving = r_moving;
        n_last   = r_last;
        n_save   = 1'b0;
        case (r_req)
            sphc_pkg::REQ_TICK: begin
                if (step_go) begin
                    n_dir    = up ^ r_reverse;
                    n_step   = !r_step;
                    if (up) begin
                        if (r_pos != sphc_pkg::POS_MAX) n_pos = r_pos + PW'(1);
                    end else begin
                        if (r_pos != sphc_pkg::POS_ZERO) n_pos = r_pos - PW'(1);
                    end
                    n_moving = 1'b1;
                    n_save   = 1'b1;
                end else begin
                    n_save   = r_moving;
                    n_moving = 1'b0;
                end
            end
            sphc_pkg::REQ_TARGET: begin
                n_set = r_tgt;
            end
            sphc_pkg::REQ_HOME: begin
                n_homing = 1'b1;
            end
            sphc_pkg::REQ_STALL: begin
                if ((r_load < r_threshold) && r_moving && (elapsed > holdoff_ext)) begin
                    n_last = r_now;
                    if (r_homing) begin
                        n_set = r_pos;
                        if (!r_tmax && r_home_zero) begin
                            n_set  = sphc_pkg::POS_ZERO;
                            n_pos  = sphc_pkg::POS_ZERO;
                            n_tmax = 1'b1;
                            if (!r_home_max) begin
                                n_homing = 1'b0;
                                n_tmax   = 1'b0;
                            end
                        end else if ((r_tmax && r_home_max)
                                || (!r_tmax && r_home_max && !r_home_zero)) begin
                            n_maxp   = r_pos;
                            n_tmax   = 1'b0;
                            n_homing = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        // homing direction returns to zero whenever homing is off
        if (!n_homing) n_tmax = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= sphc_pkg::POS_ZERO;
            r_set    <= sphc_pkg::POS_ZERO;
            r_maxp   <= sphc_pkg::MAX_POS_RESET;
            r_step   <= 1'b0;
            r_dir    <= 1'b0;
            r_homing <= 1'b0;
            r_tmax   <= 1'b0;
            r_moving <= 1'b0;
            r_last   <= '0;
        end else if (work) begin
            r_pos    <= n_pos;
            r_set    <= n_set;
            r_maxp   <= n_maxp;
            r_step   <= n_step;
            r_dir    <= n_dir;
            r_homing <= n_homing;
            r_tmax   <= n_tmax;
            r_moving <= n_moving;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_out_data <= {3'b000, n_save, n_homing, n_moving,
                           n_maxp, n_set, n_pos, n_dir, n_step};
        end
    end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        sphc_pkg::t_req                   kind;
        logic [sphc_pkg::POS_W-1:0]       target;
        logic                             drv;
        logic [sphc_pkg::LOAD_W-1:0]      load;
        logic [sphc_pkg::TIME_W-1:0]      stamp;
    } t_request;

    typedef struct {
        logic                       step;
        logic                       dir;
        logic [sphc_pkg::POS_W-1:0] pos;
        logic [sphc_pkg::POS_W-1:0] goal;
        logic [sphc_pkg::POS_W-1:0] far_end;
        logic                       moving;
        logic                       homing;
        logic                       save;
    } t_status;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [sphc_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [sphc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // target_position, driver_enabled, load_value, now_ms, zero pad
    logic [sphc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // req_type
    logic [sphc_pkg::REQ_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // step_level, dir_level, position_now, target_now, max_position_now,
    // moving, homing_active, save_request, zero pad
    logic [sphc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    stepper_position_homing_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // controller copy
    logic                           cfg_reverse = 1'b0;
    logic                           cfg_zero_end = 1'b0;
    logic                           cfg_far_end = 1'b0;
    logic [sphc_pkg::THRESH_W-1:0]  cfg_threshold = sphc_pkg::THRESH_RESET;
    logic [sphc_pkg::HOLDOFF_W-1:0] cfg_holdoff = sphc_pkg::HOLDOFF_RESET;
    logic [sphc_pkg::POS_W-1:0]     pos_q = sphc_pkg::POS_ZERO;
    logic [sphc_pkg::POS_W-1:0]     goal_q = sphc_pkg::POS_ZERO;
    logic [sphc_pkg::POS_W-1:0]     far_end_q = sphc_pkg::MAX_POS_RESET;
    logic                           step_pin_q = 1'b0;
    logic                           dir_pin_q = 1'b0;
    logic                           seeking_q = 1'b0;
    logic                           seek_up_q = 1'b0;
    logic                           in_motion_q = 1'b0;
    logic [sphc_pkg::TIME_W-1:0]    last_stall_q = '0;

    t_request                    pending_requests[$];
    t_status                     expected_status[$];
    t_request                    in_flight;
    logic                        req_fire = 1'b0;
    logic [sphc_pkg::TIME_W-1:0] stamp_clock = '0;
    int                          n_queued = 0;
    int                          n_accepted = 0;
    int                          sender_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          mismatches = 0;
    int                          cycle_count = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_status apply_request(t_request r);
        t_status s;
        logic    up;
        logic    pulse;
        pulse = 1'b0;
        case (r.kind)
            sphc_pkg::REQ_TICK: begin
                if ((pos_q != goal_q || seeking_q) && r.drv) begin
                    up = seeking_q ? seek_up_q : (pos_q < goal_q);
                    dir_pin_q = up ^ cfg_reverse;
                    step_pin_q = ~step_pin_q;
                    if (up && pos_q != sphc_pkg::POS_MAX) begin
                        pos_q = pos_q + 32'd1;
                    end else if (!up && pos_q != sphc_pkg::POS_ZERO) begin
                        pos_q = pos_q - 32'd1;
                    end
                    in_motion_q = 1'b1;
                    pulse = 1'b1;
                end else begin
                    pulse = in_motion_q;
                    in_motion_q = 1'b0;
                end
            end
            sphc_pkg::REQ_TARGET: goal_q = r.target;
            sphc_pkg::REQ_HOME: seeking_q = 1'b1;
            sphc_pkg::REQ_STALL: begin
                if (r.load < cfg_threshold && in_motion_q &&
                    (r.stamp - last_stall_q) > {16'b0, cfg_holdoff}) begin
                    if (seeking_q) begin
                        goal_q = pos_q;
                        if (!seek_up_q && cfg_zero_end) begin
                            goal_q = sphc_pkg::POS_ZERO;
                            pos_q = sphc_pkg::POS_ZERO;
                            seek_up_q = 1'b1;
                            if (!cfg_far_end) begin
                                seeking_q = 1'b0;
                                seek_up_q = 1'b0;
                            end
                        end else if ((seek_up_q && cfg_far_end) ||
                                     (!seek_up_q && cfg_far_end && !cfg_zero_end)) begin
                            far_end_q = pos_q;
                            seek_up_q = 1'b0;
                            seeking_q = 1'b0;
                        end
                    end
                    last_stall_q = r.stamp;
                end
            end
            default: ;
        endcase
        if (!seeking_q) begin
            seek_up_q = 1'b0;
        end
        s.step = step_pin_q;
        s.dir = dir_pin_q;
        s.pos = pos_q;
        s.goal = goal_q;
        s.far_end = far_end_q;
        s.moving = in_motion_q;
        s.homing = seeking_q;
        s.save = pulse;
        return s;
    endfunction

    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        int unsigned hold;
        logic [31:0] rnd;
        hold = 32'(cfg_holdoff);
        pick = $urandom_range(0, 99);
        r.target = $urandom;
        r.drv = ($urandom_range(0, 9) != 0);
        rnd = $urandom;
        r.load = rnd[sphc_pkg::LOAD_W-1:0];
        r.stamp = $urandom;
        if (pick < 55) begin
            r.kind = sphc_pkg::REQ_TICK;
        end else if (pick < 67) begin
            r.kind = sphc_pkg::REQ_TARGET;
            if ($urandom_range(0, 7) != 0) begin
                r.target = $urandom_range(0, 300);
            end
        end else if (pick < 75) begin
            r.kind = sphc_pkg::REQ_HOME;
        end else begin
            r.kind = sphc_pkg::REQ_STALL;
            if ($urandom_range(0, 4) != 0 && cfg_threshold != 0) begin
                rnd = $urandom_range(0, 32'(cfg_threshold) - 1);
                r.load = rnd[sphc_pkg::LOAD_W-1:0];
            end
            if ($urandom_range(0, 7) != 0) begin
                stamp_clock = stamp_clock + $urandom_range(hold / 2, hold * 2 + 2);
                r.stamp = stamp_clock;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic add_request(input sphc_pkg::t_req kind,
                               input logic [sphc_pkg::POS_W-1:0] target,
                               input logic drv, input logic [sphc_pkg::LOAD_W-1:0] load,
                               input logic [sphc_pkg::TIME_W-1:0] stamp);
        t_request r;
        r.kind = kind;
        r.target = target;
        r.drv = drv;
        r.load = load;
        r.stamp = stamp;
        pending_requests.push_back(r);
        n_queued++;
    endtask

    task automatic queue_batch(input int count);
        @(posedge i_clk);
        repeat (count) begin
            pending_requests.push_back(random_request());
            n_queued++;
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (n_accepted != n_queued || expected_status.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sphc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [sphc_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        case (idx)
            sphc_pkg::CFG_REVERSE:   cfg_reverse = value[0];
            sphc_pkg::CFG_HOME_ZERO: cfg_zero_end = value[0];
            sphc_pkg::CFG_HOME_MAX:  cfg_far_end = value[0];
            sphc_pkg::CFG_THRESHOLD: cfg_threshold = value[sphc_pkg::THRESH_W-1:0];
            sphc_pkg::CFG_HOLDOFF:   cfg_holdoff = value[sphc_pkg::HOLDOFF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [sphc_pkg::CFG_DATA_W-1:0] rev, zero_end, far_end,
                             input logic [sphc_pkg::CFG_DATA_W-1:0] thr, hold,
                             input int sidle, input int rstall);
        write_reg(sphc_pkg::CFG_REVERSE, rev);
        write_reg(sphc_pkg::CFG_HOME_ZERO, zero_end);
        write_reg(sphc_pkg::CFG_HOME_MAX, far_end);
        write_reg(sphc_pkg::CFG_THRESHOLD, thr);
        write_reg(sphc_pkg::CFG_HOLDOFF, hold);
        sender_idle_pct = sidle;
        recv_stall_pct = rstall;
        queue_batch(87);
        wait_drained();
        queue_batch(88);
        wait_drained();
    endtask

    always @(negedge i_clk) begin : drive_requests
        t_request nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_fire) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                nxt = pending_requests.pop_front();
                in_flight = nxt;
                s_axis_tdata <= {5'b0, nxt.stamp, nxt.load, nxt.drv, nxt.target};
                s_axis_tuser <= nxt.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_status got;
        t_status want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end else begin
            req_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
            if (req_fire) begin
                expected_status.push_back(apply_request(in_flight));
                n_accepted++;
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.step = m_axis_tdata[0];
                got.dir = m_axis_tdata[1];
                got.pos = m_axis_tdata[33:2];
                got.goal = m_axis_tdata[65:34];
                got.far_end = m_axis_tdata[97:66];
                got.moving = m_axis_tdata[98];
                got.homing = m_axis_tdata[99];
                got.save = m_axis_tdata[100];
                if (expected_status.size() == 0) begin
                    report_mismatch("result transaction with nothing pending");
                end else begin
                    want = expected_status.pop_front();
                    if (got.step !== want.step)
                        report_mismatch($sformatf("step_level %b, want %b", got.step, want.step));
                    if (got.dir !== want.dir)
                        report_mismatch($sformatf("dir_level %b, want %b", got.dir, want.dir));
                    if (got.pos !== want.pos)
                        report_mismatch($sformatf("position_now %h, want %h", got.pos, want.pos));
                    if (got.goal !== want.goal)
                        report_mismatch($sformatf("target_now %h, want %h", got.goal, want.goal));
                    if (got.far_end !== want.far_end)
                        report_mismatch($sformatf("max_position_now %h, want %h",
                                                  got.far_end, want.far_end));
                    if (got.moving !== want.moving)
                        report_mismatch($sformatf("moving %b, want %b", got.moving, want.moving));
                    if (got.homing !== want.homing)
                        report_mismatch($sformatf("homing_active %b, want %b",
                                                  got.homing, want.homing));
                    if (got.save !== want.save)
                        report_mismatch($sformatf("save_request %b, want %b", got.save, want.save));
                end
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        @(posedge i_clk);
        add_request(sphc_pkg::REQ_TICK, '0, 1'b1, '0, '0);
        add_request(sphc_pkg::REQ_TARGET, 32'd3, 1'b0, '0, '0);
        add_request(sphc_pkg::REQ_TICK, '0, 1'b0, '0, '0);
        repeat (4) add_request(sphc_pkg::REQ_TICK, sphc_pkg::POS_MAX, 1'b1, '1, '1);
        add_request(sphc_pkg::REQ_TICK, '0, 1'b1, '0, '0);
        add_request(sphc_pkg::REQ_TARGET, sphc_pkg::POS_MAX, 1'b1, '1, '0);
        add_request(sphc_pkg::REQ_TICK, '0, 1'b1, '0, '0);
        // load not below threshold, then inside holdoff, then accepted outside homing
        add_request(sphc_pkg::REQ_STALL, '0, 1'b1, '1, 32'd1000);
        add_request(sphc_pkg::REQ_STALL, '0, 1'b1, '0, 32'd400);
        add_request(sphc_pkg::REQ_STALL, '0, 1'b1, '0, 32'd501);
        add_request(sphc_pkg::REQ_HOME, '0, 1'b1, '0, '0);
        add_request(sphc_pkg::REQ_HOME, '0, 1'b1, '0, '0);
        add_request(sphc_pkg::REQ_TICK, '0, 1'b1, '0, '0);
        add_request(sphc_pkg::REQ_STALL, '0, 1'b1, '0, 32'hFFFF_FFFF);
        add_request(sphc_pkg::REQ_TARGET, '0, 1'b1, '0, '0);
        // homing toward zero runs into the lower bound
        repeat (5) add_request(sphc_pkg::REQ_TICK, '0, 1'b1, '0, '0);
        // elapsed time across the timestamp wrap
        add_request(sphc_pkg::REQ_STALL, '0, 1'b0, 10'd39, 32'h0000_01F3);
        add_request(sphc_pkg::REQ_STALL, '0, 1'b0, 10'd39, 32'h0000_01F4);
        wait_drained();

        stamp_clock = 32'h0000_1000;
        write_reg('1, '1);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 0, 0);
        run_phase(16'd0, 16'd1, 16'd0, 16'd512, 16'd100, 75, 0);
        run_phase(16'd1, 16'd0, 16'd1, 16'd1023, 16'd65535, 0, 75);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10, 10);
        run_phase(16'd1, 16'd1, 16'd1, 16'd600, 16'd20, 0, 0);
        run_phase(16'd0, 16'd0, 16'd1, 16'd1023, 16'd1, 75, 0);
        run_phase(16'd1, 16'd1, 16'd1, 16'd300, 16'd65535, 0, 75);
        run_phase(16'd0, 16'd1, 16'd1, 16'd40, 16'd500, 10, 10);

        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
